### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("concurrent check failed");

// Condition that must never be true.
`define ASSERT_NEVER(lbl, cond) `ASSERT_CLK(lbl, !(cond))

`endif

### rtl/e2q_pkg.sv
// Types and constants of the Euler angle to quaternion converter.
package e2q_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_BITS      = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int NUM_AXES  = 3;
  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_YAW   = 2;

  localparam int FRAC      = 30;
  localparam int XY_W      = 32;
  localparam int Z_W       = 34;
  localparam int STAGE_W   = 5;
  localparam int ANGLE_SH  = 32 - ANGLE_BITS;
  localparam int LATENCY   = CORDIC_STAGES + 3;

  localparam logic signed [XY_W-1:0] KINV_Q30 = 32'sh26DD3B6A;

  // arctangent of 2^-i, 2*pi = 2^32
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic                       valid;
    rot_t [NUM_AXES-1:0]        axis;
  } cell_t;

endpackage

### rtl/e2q_cordic_cell.sv
// One CORDIC rotation step for the roll, pitch and yaw lanes.
module e2q_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [e2q_pkg::STAGE_W-1:0]   stage_idx_i,
  input  e2q_pkg::cell_t                d_i,
  output e2q_pkg::cell_t                q_o
);

  logic                                   valid_q;
  e2q_pkg::rot_t [e2q_pkg::NUM_AXES-1:0] axis_d, axis_q;
  logic signed [e2q_pkg::Z_W-1:0]         step;

  assign step = e2q_pkg::Z_W'({e2q_pkg::ATAN_TAB[stage_idx_i], 1'b0});

  always_comb begin
    for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
      if (!d_i.axis[a].z[e2q_pkg::Z_W-1]) begin
        axis_d[a].x = d_i.axis[a].x - (d_i.axis[a].y >>> stage_idx_i);
        axis_d[a].y = d_i.axis[a].y + (d_i.axis[a].x >>> stage_idx_i);
        axis_d[a].z = d_i.axis[a].z - step;
      end else begin
        axis_d[a].x = d_i.axis[a].x + (d_i.axis[a].y >>> stage_idx_i);
        axis_d[a].y = d_i.axis[a].y - (d_i.axis[a].x >>> stage_idx_i);
        axis_d[a].z = d_i.axis[a].z + step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
  end

  assign q_o.valid = valid_q;
  assign q_o.axis  = axis_q;

endmodule

### rtl/e2q_combine.sv
// Product, sum and rounding stages that form the quaternion components.
module e2q_combine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  e2q_pkg::cell_t                       d_i,
  output logic                                 valid_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]  quat_x_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]  quat_y_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]  quat_z_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]  quat_w_o
);

  localparam int XY_W   = e2q_pkg::XY_W;
  localparam int PROD_W = 2 * XY_W;
  localparam int SUM_W  = XY_W + 2;
  localparam int OUT_W  = e2q_pkg::OUT_BITS;
  localparam int OUT_SH = 32 - OUT_W;
  localparam int RND    = (OUT_SH == 0) ? 0 : (1 << (OUT_SH - 1));
  localparam logic signed [SUM_W-1:0] LIM = SUM_W'(1 << (OUT_W - 2));

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] v;
    v = (s + SUM_W'(RND)) >>> OUT_SH;
    if (v > LIM) begin
      v = LIM;
    end else if (v < -LIM) begin
      v = -LIM;
    end
    return OUT_W'(v);
  endfunction

  function automatic logic signed [XY_W-1:0] qmul(input logic signed [XY_W-1:0] a,
                                                  input logic signed [XY_W-1:0] b);
    logic signed [PROD_W-1:0] m;
    m = a * b;
    return XY_W'(m >>> e2q_pkg::FRAC);
  endfunction

  logic signed [XY_W-1:0] cr, sr, cp, sp, cy, sy;

  // stage A: pitch and yaw pair products
  logic                   a_valid_q;
  logic signed [XY_W-1:0] cysp_q, sycp_q, cycp_q, sysp_q, cr_q, sr_q;

  // stage B: three-factor products
  logic                   b_valid_q;
  logic signed [XY_W-1:0] prod_d [8];
  logic signed [XY_W-1:0] prod_q [8];

  // stage C: sums, rounding, clamp
  logic                    c_valid_q;
  logic signed [OUT_W-1:0] qx_d, qy_d, qz_d, qw_d;
  logic signed [OUT_W-1:0] qx_q, qy_q, qz_q, qw_q;

  assign cr = d_i.axis[e2q_pkg::AXIS_ROLL].x;
  assign sr = d_i.axis[e2q_pkg::AXIS_ROLL].y;
  assign cp = d_i.axis[e2q_pkg::AXIS_PITCH].x;
  assign sp = d_i.axis[e2q_pkg::AXIS_PITCH].y;
  assign cy = d_i.axis[e2q_pkg::AXIS_YAW].x;
  assign sy = d_i.axis[e2q_pkg::AXIS_YAW].y;

  always_comb begin
    prod_d[0] = qmul(cysp_q, cr_q);
    prod_d[1] = qmul(sycp_q, sr_q);
    prod_d[2] = qmul(sycp_q, cr_q);
    prod_d[3] = qmul(cysp_q, sr_q);
    prod_d[4] = qmul(cycp_q, sr_q);
    prod_d[5] = qmul(sysp_q, cr_q);
    prod_d[6] = qmul(cycp_q, cr_q);
    prod_d[7] = qmul(sysp_q, sr_q);
  end

  always_comb begin
    qx_d = to_out(SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]));
    qy_d = to_out(SUM_W'(prod_q[2]) - SUM_W'(prod_q[3]));
    qz_d = to_out(SUM_W'(prod_q[4]) - SUM_W'(prod_q[5]));
    qw_d = to_out(SUM_W'(prod_q[6]) + SUM_W'(prod_q[7]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= d_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cysp_q <= qmul(cy, sp);
    sycp_q <= qmul(sy, cp);
    cycp_q <= qmul(cy, cp);
    sysp_q <= qmul(sy, sp);
    cr_q   <= cr;
    sr_q   <= sr;
    for (int i = 0; i < 8; i++) begin
      prod_q[i] <= prod_d[i];
    end
    qx_q <= qx_d;
    qy_q <= qy_d;
    qz_q <= qz_d;
    qw_q <= qw_d;
  end

  assign valid_o  = c_valid_q;
  assign quat_x_o = qx_q;
  assign quat_y_o = qy_q;
  assign quat_z_o = qz_q;
  assign quat_w_o = qw_q;

endmodule

### rtl/euler_to_quaternion.sv
// Top level: roll, pitch, yaw binary angles to unit rotation quaternion.
//
//  channel   ports                                   handshake
//  item in   roll/pitch/yaw_angle_i (16b signed)     start_i while busy_o low
//  item out  quat_x/y/z/w_o (16b signed Q1.14)       done_o, one cycle
//
// One item per cycle, every cycle; busy_o stays low.
// Pipeline: one registered cell per CORDIC step, then three product/sum
// stages, so the CORDIC cell chain makes up most of the pipeline.
// Reset clears only the valid bits along the chain.
// The receiver cannot stall: done_o marks a result for exactly one cycle.
`include "assert_macros.svh"

module euler_to_quaternion (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  roll_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  pitch_angle_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  yaw_angle_i,
  output logic                                   done_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]    quat_x_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]    quat_y_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]    quat_z_o,
  output logic signed [e2q_pkg::OUT_BITS-1:0]    quat_w_o
);

  localparam int Z_W = e2q_pkg::Z_W;
  localparam logic signed [e2q_pkg::OUT_BITS-1:0] QMAX =
    e2q_pkg::OUT_BITS'(1 << (e2q_pkg::OUT_BITS - 2));

  e2q_pkg::cell_t chain [e2q_pkg::CORDIC_STAGES+1];
  logic           accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // half angle in units where pi = 2^32
  always_comb begin
    chain[0].valid = accept;
    chain[0].axis[e2q_pkg::AXIS_ROLL].z  = Z_W'(roll_angle_i) <<< e2q_pkg::ANGLE_SH;
    chain[0].axis[e2q_pkg::AXIS_PITCH].z = Z_W'(pitch_angle_i) <<< e2q_pkg::ANGLE_SH;
    chain[0].axis[e2q_pkg::AXIS_YAW].z   = Z_W'(yaw_angle_i) <<< e2q_pkg::ANGLE_SH;
    for (int a = 0; a < e2q_pkg::NUM_AXES; a++) begin
      chain[0].axis[a].x = e2q_pkg::KINV_Q30;
      chain[0].axis[a].y = '0;
    end
  end

  for (genvar g = 0; g < e2q_pkg::CORDIC_STAGES; g++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_idx_i (e2q_pkg::STAGE_W'(g)),
      .d_i         (chain[g]),
      .q_o         (chain[g+1])
    );
  end

  e2q_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .d_i      (chain[e2q_pkg::CORDIC_STAGES]),
    .valid_o  (done_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o),
    .quat_w_o (quat_w_o)
  );

  `ASSERT_CLK(a_item_done, accept |-> ##(e2q_pkg::LATENCY) done_o)
  `ASSERT_CLK(a_done_has_item, done_o |-> $past(accept, e2q_pkg::LATENCY))
  `ASSERT_NEVER(a_out_range, done_o && (quat_x_o > QMAX || quat_x_o < -QMAX ||
    quat_y_o > QMAX || quat_y_o < -QMAX || quat_z_o > QMAX || quat_z_o < -QMAX ||
    quat_w_o > QMAX || quat_w_o < -QMAX))

endmodule

### dv/euler_to_quaternion_tb.sv
// Self-checking testbench for the Euler angle to quaternion converter.
`timescale 1ns / 100ps

module euler_to_quaternion_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = e2q_pkg::CORDIC_STAGES + 8;
  localparam int PRINT_CAP = 40;

  typedef logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_t;
  typedef logic signed [e2q_pkg::OUT_BITS-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  angle_t roll_angle_i;
  angle_t pitch_angle_i;
  angle_t yaw_angle_i;
  logic   done_o;
  comp_t  quat_x_o;
  comp_t  quat_y_o;
  comp_t  quat_z_o;
  comp_t  quat_w_o;

  quat_t quat_expected[$];
  quat_t quat_want;
  int    error_count = 0;
  int    cycle_count = 0;

  euler_to_quaternion dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .roll_angle_i  (roll_angle_i),
    .pitch_angle_i (pitch_angle_i),
    .yaw_angle_i   (yaw_angle_i),
    .done_o        (done_o),
    .quat_x_o      (quat_x_o),
    .quat_y_o      (quat_y_o),
    .quat_z_o      (quat_z_o),
    .quat_w_o      (quat_w_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sine and cosine of half the angle, Q30, by rotation-mode CORDIC
  function automatic void half_angle_sincos(input angle_t ang, output longint cos_q30,
                                            output longint sin_q30);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint step;
    int     n;
    x = longint'(e2q_pkg::KINV_Q30);
    y = 0;
    z = longint'(ang) * (longint'(1) << (32 - e2q_pkg::ANGLE_BITS));
    n = (e2q_pkg::CORDIC_STAGES > 32) ? 32 : e2q_pkg::CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = 2 * longint'(e2q_pkg::ATAN_TAB[i % 32]);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= step;
      end else begin
        x += dx;
        y -= dy;
        z += step;
      end
    end
    cos_q30 = x;
    sin_q30 = y;
  endfunction

  function automatic longint triple_product(input longint a, input longint b, input longint c);
    return (((a * b) >>> 30) * c) >>> 30;
  endfunction

  // Q30 sum to Q1.14, round half up, clamp to +-1
  function automatic comp_t round_to_component(input longint q30);
    longint v;
    longint lim;
    int     sh;
    sh = 32 - e2q_pkg::OUT_BITS;
    lim = longint'(1) << (e2q_pkg::OUT_BITS - 2);
    v = q30;
    if (sh > 0) v = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[e2q_pkg::OUT_BITS-1:0];
  endfunction

  function automatic quat_t quaternion_of(input angle_t roll, input angle_t pitch,
                                          input angle_t yaw);
    longint cr;
    longint sr;
    longint cp;
    longint sp;
    longint cy;
    longint sy;
    quat_t  q;
    half_angle_sincos(roll, cr, sr);
    half_angle_sincos(pitch, cp, sp);
    half_angle_sincos(yaw, cy, sy);
    q.x = round_to_component(triple_product(cy, sp, cr) + triple_product(sy, cp, sr));
    q.y = round_to_component(triple_product(sy, cp, cr) - triple_product(cy, sp, sr));
    q.z = round_to_component(triple_product(cy, cp, sr) - triple_product(sy, sp, cr));
    q.w = round_to_component(triple_product(cy, cp, cr) + triple_product(sy, sp, sr));
    return q;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_CAP)
      $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (quat_expected.size() == 0) begin
        report_mismatch("result with no item pending", quat_x_o, 0);
      end else begin
        quat_want = quat_expected.pop_front();
        if (quat_x_o !== quat_want.x) report_mismatch("quat_x", quat_x_o, quat_want.x);
        if (quat_y_o !== quat_want.y) report_mismatch("quat_y", quat_y_o, quat_want.y);
        if (quat_z_o !== quat_want.z) report_mismatch("quat_z", quat_z_o, quat_want.z);
        if (quat_w_o !== quat_want.w) report_mismatch("quat_w", quat_w_o, quat_want.w);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // drive one item; start_i stays high on return
  task automatic send_item(input angle_t roll, input angle_t pitch, input angle_t yaw);
    start_i       <= 1'b1;
    roll_angle_i  <= roll;
    pitch_angle_i <= pitch;
    yaw_angle_i   <= yaw;
    do @(posedge clk_i); while (busy_o);
    quat_expected.push_back(quaternion_of(roll, pitch, yaw));
  endtask

  task automatic sender_idle(input int pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (quat_expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic angle_t rand_angle();
    angle_t corners[7] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh4000, 16'shC000,
                           16'shFFFF, 16'sh0001};
    if ($urandom_range(7) == 0) return corners[$urandom_range(6)];
    return angle_t'($urandom_range(16'hFFFF));
  endfunction

  task automatic test_zero_and_limits();
    send_item(16'sh0000, 16'sh0000, 16'sh0000);
    send_item(16'sh8000, 16'sh8000, 16'sh8000);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(16'sh0001, 16'shFFFF, 16'sh0001);
    send_item(16'sh5555, 16'shAAAA, 16'sh5555);
    send_item(16'shAAAA, 16'sh5555, 16'shAAAA);
    send_item(16'sh8000, 16'sh7FFF, 16'sh0000);
    wait_drained();
  endtask

  // one axis at a time, swept over its extremes and quarter turns
  task automatic test_single_axis();
    angle_t sweep[4] = '{16'sh8000, 16'sh7FFF, 16'sh4000, 16'shC000};
    foreach (sweep[i]) begin
      send_item(sweep[i], 16'sh0000, 16'sh0000);
      send_item(16'sh0000, sweep[i], 16'sh0000);
      send_item(16'sh0000, 16'sh0000, sweep[i]);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    repeat (count) begin
      send_item(rand_angle(), rand_angle(), rand_angle());
      sender_idle(idle_pct);
    end
    wait_drained();
  endtask

  // burst, hold off until every result is back, then a second burst
  task automatic test_pause_until_drained();
    repeat (20) send_item(rand_angle(), rand_angle(), rand_angle());
    wait_drained();
    repeat (20) send_item(rand_angle(), rand_angle(), rand_angle());
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    roll_angle_i  = '0;
    pitch_angle_i = '0;
    yaw_angle_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_and_limits();
    test_single_axis();
    test_random(630, 9);
    test_random(630, 78);
    test_pause_until_drained();
    test_random(630, 0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### euler_to_quaternion.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
dv/euler_to_quaternion_tb.sv
